/* hdl/nmt_sec_pkg.sv */
// types, codes and constants shared by the nmt slave error control block
package nmt_sec_pkg;

   // input transaction
   typedef struct packed {
      logic [1:0] action;
      logic [7:0] command_code;
      logic [7:0] target_node;
   } req_type;

   // result transaction
   typedef struct packed {
      logic        frame_valid;
      logic [10:0] frame_cob_id;
      logic [7:0]  frame_byte;
      logic [1:0]  state_now;
      logic        datalink_on;
      logic [1:0]  reset_request;
      logic        sync_clear;
      logic        guard_event;
      logic        guard_resolved;
   } rsp_type;

   // actions
   localparam logic [1:0] ACT_COMMAND = 2'd0;
   localparam logic [1:0] ACT_TICK    = 2'd1;
   localparam logic [1:0] ACT_GUARD   = 2'd2;
   localparam logic [1:0] ACT_BOOT    = 2'd3;

   // nmt command specifiers
   localparam logic [7:0] CMD_START      = 8'd1;
   localparam logic [7:0] CMD_STOP       = 8'd2;
   localparam logic [7:0] CMD_PREOP      = 8'd128;
   localparam logic [7:0] CMD_RESET_NODE = 8'd129;
   localparam logic [7:0] CMD_RESET_COMM = 8'd130;

   // node modes
   localparam logic [1:0] MODE_INIT  = 2'd0;
   localparam logic [1:0] MODE_PREOP = 2'd1;
   localparam logic [1:0] MODE_OPER  = 2'd2;
   localparam logic [1:0] MODE_STOP  = 2'd3;

   // reset requests
   localparam logic [1:0] RST_NONE = 2'd0;
   localparam logic [1:0] RST_NODE = 2'd1;
   localparam logic [1:0] RST_COMM = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_NODE_ID     = 2'd0;
   localparam logic [1:0] CSR_HEARTBEAT   = 2'd1;
   localparam logic [1:0] CSR_GUARD_TIME  = 2'd2;
   localparam logic [1:0] CSR_LIFE_FACTOR = 2'd3;

   // frame state codes
   localparam logic [6:0] CODE_INIT  = 7'h00;
   localparam logic [6:0] CODE_PREOP = 7'h7F;
   localparam logic [6:0] CODE_OPER  = 7'h05;
   localparam logic [6:0] CODE_STOP  = 7'h04;

   localparam logic [10:0] COB_BASE = 11'h700;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   // millisecond count times 1000 fits in 26 bits
   localparam int          NUM_W    = 26;
   localparam logic [NUM_W-1:0] MS_TO_US = 26'd1000;

   function automatic logic [6:0] state_code(input logic [1:0] mode);
      logic [6:0] code;
      case (mode)
         MODE_PREOP: code = CODE_PREOP;
         MODE_OPER:  code = CODE_OPER;
         MODE_STOP:  code = CODE_STOP;
         default:    code = CODE_INIT;
      endcase
      return code;
   endfunction

endpackage

/* hdl/nmt_slave_error_control.sv */
// nmt slave state, heartbeat producer and life guarding with output skid buffer
//
//   channel  | dir | handshake             | payload
//   req_     | in  | req_valid / req_stall | req_data (action, command, target)
//   rsp_     | out | rsp_valid / rsp_stall | rsp_data (frame, status, pulses)
//   csr_     | in  | csr_wr_en             | csr_index, csr_wdata
//
// one transaction per cycle when not stalled, result registered on acceptance
// a write to heartbeat, guard time or life factor recomputes the reloads in steps
// (scale to us, multiply by the reciprocal of TICK_US, life product and load)
// req_stall is high during the recompute
// synchronous active-high reset, no recompute needed after it
// a two-entry output (register plus skid) keeps input open while one result waits
module nmt_slave_error_control
   import nmt_sec_pkg::*;
#(
   parameter int TICK_US = 1000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // exact quotient for any NUM_W-bit numerator: ceil(2^sh / TICK_US), sh = NUM_W + log2
   localparam int RECIP_SH = NUM_W + $clog2(TICK_US);
   localparam int RECIP_W  = NUM_W + 2;
   localparam int PROD_W   = NUM_W + RECIP_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SH) + 64'(TICK_US) - 64'd1) / 64'(TICK_US);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_MUL  = 2'd3;

   // configuration
   logic [6:0]  own_id_ff;
   logic [15:0] hb_ms_ff;
   logic [15:0] gt_ms_ff;
   logic [7:0]  lf_ff;

   // node state
   logic [1:0]  mode_ff, mode_in;
   logic        link_ff, link_in;
   logic [31:0] beat_reload_ff;
   logic [31:0] beat_count_ff, beat_count_in;
   logic [31:0] life_reload_ff;
   logic [31:0] life_count_ff, life_count_in;
   logic        toggle_ff, toggle_in;
   logic        gerr_ff, gerr_in;

   // reload computation
   logic [1:0]        state_ff;
   logic [NUM_W-1:0]  hb_num_ff, gt_num_ff;
   logic [PROD_W-1:0] hb_prod, gt_prod;
   logic [NUM_W:0]    life_per;
   logic [NUM_W+8:0]  life_prod;
   logic [31:0]       life_sat;
   logic [31:0]       beat_new;

   // output register and skid
   logic    rsp_valid_ff, skid_valid_ff;
   rsp_type rsp_data_ff, skid_data_ff;
   rsp_type rsp_new;

   logic       accept, take, out_free;
   logic       id_ok, addressed, put_frame;
   logic [7:0] put_byte;

   assign accept    = req_valid && !req_stall;
   assign take      = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || take;
   assign req_stall = (state_ff != ST_IDLE) || skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign id_ok     = (own_id_ff != 7'd0);
   assign addressed = (req_data.target_node == 8'd0)
                   || (req_data.target_node == {1'b0, own_id_ff});

   // transaction decode and next state
   always_comb begin
      mode_in       = mode_ff;
      link_in       = link_ff;
      beat_count_in = beat_count_ff;
      life_count_in = life_count_ff;
      toggle_in     = toggle_ff;
      gerr_in       = gerr_ff;
      put_frame     = 1'b0;
      put_byte      = 8'd0;
      rsp_new       = '0;
      unique case (req_data.action)
         ACT_COMMAND: begin
            if (addressed) begin
               if (req_data.command_code == CMD_RESET_NODE
                   || req_data.command_code == CMD_RESET_COMM) begin
                  link_in = 1'b0;
                  mode_in = MODE_INIT;
                  rsp_new.reset_request = (req_data.command_code == CMD_RESET_NODE)
                                          ? RST_NODE : RST_COMM;
               end else begin
                  link_in = 1'b1;
                  case (req_data.command_code)
                     CMD_START: mode_in = MODE_OPER;
                     CMD_STOP: begin
                        mode_in = MODE_STOP;
                        rsp_new.sync_clear = 1'b1;
                     end
                     CMD_PREOP: begin
                        if (mode_ff != MODE_INIT) begin
                           mode_in = MODE_PREOP;
                        end else if (id_ok) begin
                           mode_in   = MODE_PREOP;
                           put_frame = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         ACT_TICK: begin
            if (mode_ff != MODE_INIT) begin
               if (beat_reload_ff != 32'd0) begin
                  if (beat_count_ff != 32'd0) begin
                     beat_count_in = beat_count_ff - 32'd1;
                     if (beat_count_ff == 32'd1) begin
                        beat_count_in = beat_reload_ff;
                        put_frame     = 1'b1;
                        put_byte      = {1'b0, state_code(mode_ff)};
                     end
                  end
               end else if (life_reload_ff != 32'd0) begin
                  if (life_count_ff != 32'd0) begin
                     life_count_in = life_count_ff - 32'd1;
                     if (life_count_ff == 32'd1) begin
                        gerr_in             = 1'b1;
                        rsp_new.guard_event = 1'b1;
                     end
                  end
               end
            end
         end
         ACT_GUARD: begin
            if (beat_reload_ff == 32'd0) begin
               put_frame = 1'b1;
               put_byte  = {toggle_ff, state_code(mode_ff)};
               toggle_in = !toggle_ff;
               if (life_reload_ff != 32'd0) begin
                  life_count_in = life_reload_ff;
                  if (gerr_ff) begin
                     gerr_in                = 1'b0;
                     rsp_new.guard_resolved = 1'b1;
                  end
               end
            end
         end
         ACT_BOOT: begin
            if (mode_ff == MODE_INIT && id_ok) begin
               mode_in   = MODE_PREOP;
               put_frame = 1'b1;
            end
         end
      endcase
      if (put_frame && id_ok) begin
         rsp_new.frame_valid  = 1'b1;
         rsp_new.frame_cob_id = COB_BASE + {4'd0, own_id_ff};
         rsp_new.frame_byte   = put_byte;
      end
      rsp_new.state_now   = mode_in;
      rsp_new.datalink_on = link_in;
   end

   // divide by TICK_US as a multiply by its rounded-up reciprocal
   always_comb begin
      hb_prod = PROD_W'(hb_num_ff) * PROD_W'(RECIP);
      gt_prod = PROD_W'(gt_num_ff) * PROD_W'(RECIP);
   end

   // reload values from quotients
   always_comb begin
      life_per  = {1'b0, gt_num_ff} + {{NUM_W{1'b0}}, 1'b1};
      life_prod = (NUM_W+9)'(life_per) * (NUM_W+9)'(lf_ff);
      life_sat  = (life_prod[NUM_W+8:32] != '0) ? ALL_ONES : life_prod[31:0];
      if (hb_ms_ff == 16'd0) begin
         beat_new = 32'd0;
      end else if (hb_num_ff == '0) begin
         beat_new = 32'd1;
      end else begin
         beat_new = 32'(hb_num_ff);
      end
   end

   // configuration registers and reload sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= 7'd1;
         hb_ms_ff  <= 16'd0;
         gt_ms_ff  <= 16'd0;
         lf_ff     <= 8'd0;
         state_ff  <= ST_IDLE;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_NODE_ID:     own_id_ff <= csr_wdata[6:0];
               CSR_HEARTBEAT:   hb_ms_ff  <= csr_wdata;
               CSR_GUARD_TIME:  gt_ms_ff  <= csr_wdata;
               default:         lf_ff     <= csr_wdata[7:0];
            endcase
         end
         if (csr_wr_en && csr_index != CSR_NODE_ID) begin
            state_ff <= ST_LOAD;
         end else begin
            unique case (state_ff)
               ST_LOAD: state_ff <= ST_DIV;
               ST_DIV:  state_ff <= ST_MUL;
               ST_MUL:  state_ff <= ST_IDLE;
               default: state_ff <= ST_IDLE;
            endcase
         end
      end
   end

   // divider datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         hb_num_ff <= NUM_W'(hb_ms_ff) * MS_TO_US;
         gt_num_ff <= NUM_W'(gt_ms_ff) * MS_TO_US;
      end else if (state_ff == ST_DIV) begin
         hb_num_ff <= NUM_W'(hb_prod >> RECIP_SH);
         gt_num_ff <= NUM_W'(gt_prod >> RECIP_SH);
      end
   end

   // node state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_INIT;
         link_ff        <= 1'b1;
         beat_reload_ff <= 32'd0;
         beat_count_ff  <= ALL_ONES;
         life_reload_ff <= 32'd0;
         life_count_ff  <= ALL_ONES;
         toggle_ff      <= 1'b0;
         gerr_ff        <= 1'b0;
      end else if (state_ff == ST_MUL) begin
         beat_reload_ff <= beat_new;
         beat_count_ff  <= (beat_new == 32'd0) ? ALL_ONES : beat_new;
         life_reload_ff <= (gt_ms_ff == 16'd0) ? 32'd0 : life_sat;
         life_count_ff  <= ALL_ONES;
         gerr_ff        <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         link_ff       <= link_in;
         beat_count_ff <= beat_count_in;
         life_count_ff <= life_count_in;
         toggle_ff     <= toggle_in;
         gerr_ff       <= gerr_in;
      end
   end

   // output register and skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_free) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (accept) begin
         if (out_free) begin
            rsp_data_ff <= rsp_new;
         end else begin
            skid_data_ff <= rsp_new;
         end
      end
   end

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a transaction while the output register is empty");

   a_beat_nonzero: assert property (@(posedge clock) disable iff (reset)
      (beat_reload_ff != 32'd0) |-> (beat_count_ff != 32'd0))
      else $error("heartbeat counter reached zero without reload");

   a_guard_err_needs_life: assert property (@(posedge clock) disable iff (reset)
      gerr_ff |-> (life_reload_ff != 32'd0))
      else $error("life guarding error set with life guarding off");

   a_reset_req_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.reset_request != RST_NONE)
      |-> (rsp_data.state_now == MODE_INIT && !rsp_data.datalink_on))
      else $error("reset request without initialising state and link off");
`endif

endmodule

/* tb/tb.sv */
// self-checking testbench for the nmt slave error control block
`timescale 1ns / 100ps

module tb;
   import nmt_sec_pkg::*;

   localparam int TICK_US = 1000;
   localparam int RANDOM_ITEMS = 1650;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_NODE_ID;
   logic [15:0] csr_wdata = '0;

   req_type     pending_q[$];
   rsp_type     expected_q[$];
   int unsigned error_count = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   stall_kind_type stall_mode = STALL_NONE;

   // predictor state and register copies
   logic [6:0]  node_id;
   logic [15:0] beat_ms;
   logic [15:0] guard_ms;
   logic [7:0]  life_mult;
   logic [1:0]  mode;
   logic        link_on;
   logic [31:0] beat_reload, beat_cnt;
   logic [31:0] life_reload, life_cnt;
   logic        toggle;
   logic        guard_err;

   nmt_slave_error_control #(.TICK_US(TICK_US)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void reload_timers();
      logic [63:0] per;
      life_reload = '0;
      beat_reload = '0;
      life_cnt = ALL_ONES;
      beat_cnt = ALL_ONES;
      guard_err = 1'b0;
      if (beat_ms != 0) begin
         per = 64'(beat_ms) * 1000 / TICK_US;
         if (per == 0) per = 1;
         if (per > 64'(ALL_ONES)) per = 64'(ALL_ONES);
         beat_reload = per[31:0];
         beat_cnt = beat_reload;
      end
      if (guard_ms != 0) begin
         per = 64'(life_mult) * (1 + 64'(guard_ms) * 1000 / TICK_US);
         if (per > 64'(ALL_ONES)) per = 64'(ALL_ONES);
         life_reload = per[31:0];
      end
   endfunction

   function automatic void reset_model();
      node_id = 7'd1;
      beat_ms = '0;
      guard_ms = '0;
      life_mult = '0;
      mode = MODE_INIT;
      link_on = 1'b1;
      toggle = 1'b0;
      reload_timers();
   endfunction

   function automatic void config_model(logic [1:0] idx, logic [15:0] val);
      case (idx)
         CSR_NODE_ID: node_id = val[6:0];
         CSR_HEARTBEAT: begin
            beat_ms = val;
            reload_timers();
         end
         CSR_GUARD_TIME: begin
            guard_ms = val;
            reload_timers();
         end
         default: begin
            life_mult = val[7:0];
            reload_timers();
         end
      endcase
   endfunction

   function automatic logic [6:0] mode_code(logic [1:0] m);
      case (m)
         MODE_PREOP: return CODE_PREOP;
         MODE_OPER:  return CODE_OPER;
         MODE_STOP:  return CODE_STOP;
         default:    return CODE_INIT;
      endcase
   endfunction

   function automatic rsp_type with_frame(rsp_type r, logic [7:0] b);
      if (node_id == 0) return r;
      r.frame_valid = 1'b1;
      r.frame_cob_id = COB_BASE + 11'(node_id);
      r.frame_byte = b;
      return r;
   endfunction

   function automatic rsp_type boot_up(rsp_type r);
      if (mode != MODE_INIT || node_id == 0) return r;
      mode = MODE_PREOP;
      return with_frame(r, 8'h00);
   endfunction

   function automatic rsp_type predict_status(req_type q);
      rsp_type o;
      o = '0;
      case (q.action)
         ACT_COMMAND: begin
            if (q.target_node == 0 || q.target_node == {1'b0, node_id}) begin
               if (q.command_code == CMD_RESET_NODE || q.command_code == CMD_RESET_COMM) begin
                  link_on = 1'b0;
                  mode = MODE_INIT;
                  o.reset_request = (q.command_code == CMD_RESET_NODE) ? RST_NODE : RST_COMM;
               end else begin
                  link_on = 1'b1;
                  case (q.command_code)
                     CMD_START: mode = MODE_OPER;
                     CMD_STOP: begin
                        mode = MODE_STOP;
                        o.sync_clear = 1'b1;
                     end
                     CMD_PREOP: begin
                        if (mode == MODE_INIT) o = boot_up(o);
                        else mode = MODE_PREOP;
                     end
                     default: ;
                  endcase
               end
            end
         end
         ACT_TICK: begin
            if (mode != MODE_INIT) begin
               if (beat_reload != 0) begin
                  if (beat_cnt != 0) begin
                     beat_cnt = beat_cnt - 1;
                     if (beat_cnt == 0) begin
                        beat_cnt = beat_reload;
                        o = with_frame(o, {1'b0, mode_code(mode)});
                     end
                  end
               end else if (life_reload != 0) begin
                  if (life_cnt != 0) begin
                     life_cnt = life_cnt - 1;
                     if (life_cnt == 0) begin
                        guard_err = 1'b1;
                        o.guard_event = 1'b1;
                     end
                  end
               end
            end
         end
         ACT_GUARD: begin
            if (beat_reload == 0) begin
               o = with_frame(o, {toggle, mode_code(mode)});
               toggle = ~toggle;
               if (life_reload != 0) begin
                  life_cnt = life_reload;
                  if (guard_err) begin
                     guard_err = 1'b0;
                     o.guard_resolved = 1'b1;
                  end
               end
            end
         end
         default: o = boot_up(o);
      endcase
      o.state_now = mode;
      o.datalink_on = link_on;
      return o;
   endfunction

   task automatic report_error(input string msg);
      if (error_count < 40) $display("error at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) report_error($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   task automatic check_result(input rsp_type got, input rsp_type want);
      check_field("frame_valid", 32'(got.frame_valid), 32'(want.frame_valid));
      check_field("frame_cob_id", 32'(got.frame_cob_id), 32'(want.frame_cob_id));
      check_field("frame_byte", 32'(got.frame_byte), 32'(want.frame_byte));
      check_field("state_now", 32'(got.state_now), 32'(want.state_now));
      check_field("datalink_on", 32'(got.datalink_on), 32'(want.datalink_on));
      check_field("reset_request", 32'(got.reset_request), 32'(want.reset_request));
      check_field("sync_clear", 32'(got.sync_clear), 32'(want.sync_clear));
      check_field("guard_event", 32'(got.guard_event), 32'(want.guard_event));
      check_field("guard_resolved", 32'(got.guard_resolved), 32'(want.guard_resolved));
   endtask

   // driver: bursts of random length with random gaps
   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_q.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= pending_q.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_kind_type'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 300);
         end else begin
            stall_left = stall_left - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((stall_left % 7) < 3);
         endcase
      end
   end

   // monitor: check results, then predict for the accepted transaction
   always @(posedge clock) begin : monitor
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0)
               report_error($sformatf("unexpected transaction %0h", rsp_data));
            else
               check_result(rsp_data, expected_q.pop_front());
         end
         if (req_valid && !req_stall) expected_q.push_back(predict_status(req_data));
      end
   end

   task automatic wait_idle();
      @(negedge clock);
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      config_model(idx, val);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      while (req_stall) @(negedge clock);
   endtask

   task automatic add_item(input logic [1:0] act, input logic [7:0] code, input logic [7:0] node);
      req_type q;
      q.action = act;
      q.command_code = code;
      q.target_node = node;
      pending_q.push_back(q);
   endtask

   function automatic req_type random_item();
      req_type q;
      int unsigned pick;
      q.action = ACT_TICK;
      q.command_code = 8'($urandom);
      q.target_node = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) q.action = ACT_TICK;
      else if (pick < 65) q.action = ACT_GUARD;
      else if (pick < 75) q.action = ACT_BOOT;
      else begin
         q.action = ACT_COMMAND;
         pick = $urandom_range(0, 99);
         if (pick < 22) q.command_code = CMD_START;
         else if (pick < 40) q.command_code = CMD_STOP;
         else if (pick < 70) q.command_code = CMD_PREOP;
         else if (pick < 76) q.command_code = CMD_RESET_NODE;
         else if (pick < 82) q.command_code = CMD_RESET_COMM;
         pick = $urandom_range(0, 9);
         if (pick < 3) q.target_node = 8'd0;
         else if (pick < 7) q.target_node = {1'b0, node_id};
      end
      return q;
   endfunction

   task automatic random_setup();
      logic [15:0] v;
      int unsigned r;
      if ($urandom_range(0, 3) != 0) begin
         r = $urandom_range(0, 9);
         v = (r == 0) ? 16'd0 : (r == 1) ? 16'd127 : 16'($urandom_range(1, 126));
         if ($urandom_range(0, 4) == 0) v[15:7] = 9'($urandom);
         write_reg(CSR_NODE_ID, v);
      end
      if ($urandom_range(0, 3) != 0) begin
         r = $urandom_range(0, 19);
         if (r < 9) v = 16'd0;
         else if (r < 17) v = 16'($urandom_range(1, 8));
         else if (r < 19) v = 16'($urandom_range(9, 300));
         else v = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
         write_reg(CSR_HEARTBEAT, v);
      end
      if ($urandom_range(0, 3) != 0) begin
         r = $urandom_range(0, 19);
         if (r < 8) v = 16'd0;
         else if (r < 17) v = 16'($urandom_range(1, 3));
         else if (r < 19) v = 16'($urandom_range(4, 40));
         else v = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
         write_reg(CSR_GUARD_TIME, v);
      end
      if ($urandom_range(0, 3) != 0) begin
         r = $urandom_range(0, 19);
         if (r < 3) v = 16'd0;
         else if (r < 16) v = 16'($urandom_range(1, 3));
         else if (r < 19) v = 16'($urandom_range(4, 20));
         else v = 16'd255;
         if ($urandom_range(0, 4) == 0) v[15:8] = 8'($urandom);
         write_reg(CSR_LIFE_FACTOR, v);
      end
   endtask

   initial begin : stimulus
      int unsigned sent;
      int unsigned n;
      sent = 0;
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // defaults: no heartbeat, no life guarding
      add_item(ACT_TICK, 8'd0, 8'd0);
      add_item(ACT_GUARD, 8'd0, 8'd0);
      add_item(ACT_GUARD, 8'hFF, 8'hFF);
      add_item(ACT_BOOT, 8'd0, 8'd0);
      add_item(ACT_BOOT, 8'd0, 8'd0);
      add_item(ACT_COMMAND, CMD_START, 8'd1);
      add_item(ACT_COMMAND, CMD_STOP, 8'd0);
      add_item(ACT_COMMAND, CMD_PREOP, 8'hFF);
      add_item(ACT_COMMAND, 8'hFF, 8'd0);
      add_item(ACT_COMMAND, CMD_RESET_NODE, 8'd0);
      add_item(ACT_COMMAND, CMD_PREOP, 8'd0);
      add_item(ACT_COMMAND, CMD_RESET_COMM, 8'd1);
      wait_idle();

      // top node id, fastest heartbeat, largest life time
      write_reg(CSR_NODE_ID, 16'd127);
      write_reg(CSR_GUARD_TIME, 16'hFFFF);
      write_reg(CSR_LIFE_FACTOR, 16'd255);
      write_reg(CSR_HEARTBEAT, 16'd1);
      add_item(ACT_BOOT, 8'd0, 8'd0);
      add_item(ACT_TICK, 8'd0, 8'd0);
      add_item(ACT_GUARD, 8'd0, 8'd0);
      add_item(ACT_COMMAND, CMD_START, 8'd127);
      add_item(ACT_TICK, 8'd0, 8'd0);
      wait_idle();

      // node id zero with the shortest life time
      write_reg(CSR_NODE_ID, 16'd0);
      write_reg(CSR_HEARTBEAT, 16'd0);
      write_reg(CSR_GUARD_TIME, 16'd1);
      write_reg(CSR_LIFE_FACTOR, 16'd1);
      add_item(ACT_GUARD, 8'd0, 8'd0);
      add_item(ACT_TICK, 8'd0, 8'd0);
      add_item(ACT_TICK, 8'd0, 8'd0);
      add_item(ACT_TICK, 8'd0, 8'd0);
      add_item(ACT_GUARD, 8'd0, 8'd0);
      add_item(ACT_BOOT, 8'd0, 8'd0);
      wait_idle();

      write_reg(CSR_NODE_ID, 16'd1);
      write_reg(CSR_HEARTBEAT, 16'hFFFF);
      add_item(ACT_TICK, 8'd0, 8'd0);
      add_item(ACT_GUARD, 8'd0, 8'd0);

      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         random_setup();
         n = $urandom_range(40, 120);
         repeat (n) pending_q.push_back(random_item());
         sent += n;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("nmt_slave_error_control verification clean");
      else
         $display("nmt_slave_error_control verification failed");
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("nmt_slave_error_control verification failed");
      $finish;
   end

endmodule
